// ===== src/bqd_pkg.sv =====
// Shared types, constants and fixed-point helpers for the biquad equalizer section.
`timescale 1ns / 1ps
`default_nettype none
package bqd_pkg;

  localparam int NUM_COEF = 5;

  // Coefficient slot codes
  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  // Item modes
  localparam logic MODE_FILTER = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 26;
  localparam int FB_W     = 28;
  localparam int DELAY_W  = 50;
  localparam int PROD_W   = COEF_W + FB_W;
  localparam int ACC_W    = 56;
  localparam int ADDR_W   = 9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_B0,
    ST_MUL_B0,
    ST_Y,
    ST_FB,
    ST_MUL_A1,
    ST_SUB_A1,
    ST_W1,
    ST_W2,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_PROD_W2,
    ACC_SUB_PROD,
    ACC_PROD
  } acc_op_e;

  typedef struct packed {
    logic       coef_we;
    logic       coef_re;
    logic [2:0] slot;
    logic       delay_re;
    logic       mul_en;
    logic       mul_fb;
    logic       y_load;
    logic       fb_load;
    acc_op_e    acc_op;
    logic       wr_first;
    logic       wr_second;
    logic       out_load;
    logic       out_from_y;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic tgt_ok;
    logic out_busy;
  } status_t;

  // Saturate the accumulator to the Q5.45 delay range
  function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [ACC_W-1:0] v);
    logic signed [DELAY_W-1:0] r;
    if (v[ACC_W-1:DELAY_W-1] != {(ACC_W-DELAY_W+1){v[ACC_W-1]}}) begin
      r = v[ACC_W-1] ? {1'b1, {(DELAY_W-1){1'b0}}} : {1'b0, {(DELAY_W-1){1'b1}}};
    end else begin
      r = v[DELAY_W-1:0];
    end
    return r;
  endfunction

  // Q5.45 -> Q6.23, round half up
  function automatic logic signed [28:0] round_y(input logic signed [DELAY_W-1:0] y);
    logic signed [DELAY_W:0] t;
    t = {y[DELAY_W-1], y} + (51'sd1 <<< 21);
    return t[DELAY_W:22];
  endfunction

  function automatic logic signed [FB_W-1:0] sat_fb(input logic signed [28:0] v);
    logic signed [FB_W-1:0] r;
    if (v[28] != v[27]) begin
      r = v[28] ? {1'b1, {(FB_W-1){1'b0}}} : {1'b0, {(FB_W-1){1'b1}}};
    end else begin
      r = v[FB_W-1:0];
    end
    return r;
  endfunction

  function automatic logic out_clips(input logic signed [28:0] v);
    return v[28:SAMPLE_W-1] != {(30-SAMPLE_W){v[28]}};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [28:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (out_clips(v)) begin
      r = v[28] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/bqd_ctrl.sv =====
// Sequencing state machine for the biquad section: one item at a time.
`timescale 1ns / 1ps
`default_nettype none
module bqd_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_valid_i,
  output logic                  s_ready_o,
  input  wire bqd_pkg::status_t status_i,
  output bqd_pkg::cmd_t         cmd_o
);

  bqd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bqd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bqd_pkg::ST_IDLE: begin
        if (s_valid_i) state_d = bqd_pkg::ST_DISPATCH;
      end
      bqd_pkg::ST_DISPATCH: begin
        if (status_i.is_load || !status_i.tgt_ok) begin
          state_d = bqd_pkg::ST_DONE;
        end else begin
          state_d = bqd_pkg::ST_RD_B0;
        end
      end
      bqd_pkg::ST_RD_B0:   state_d = bqd_pkg::ST_MUL_B0;
      bqd_pkg::ST_MUL_B0:  state_d = bqd_pkg::ST_Y;
      bqd_pkg::ST_Y:       state_d = bqd_pkg::ST_FB;
      bqd_pkg::ST_FB:      state_d = bqd_pkg::ST_MUL_A1;
      bqd_pkg::ST_MUL_A1:  state_d = bqd_pkg::ST_SUB_A1;
      bqd_pkg::ST_SUB_A1:  state_d = bqd_pkg::ST_W1;
      bqd_pkg::ST_W1:      state_d = bqd_pkg::ST_W2;
      bqd_pkg::ST_W2:      state_d = bqd_pkg::ST_DONE;
      bqd_pkg::ST_DONE: begin
        if (!status_i.out_busy) state_d = bqd_pkg::ST_IDLE;
      end
      default:             state_d = bqd_pkg::ST_IDLE;
    endcase
  end

  // Coefficient reads are registered ahead of the multiply that uses them
  always_comb begin
    cmd_o = '0;
    cmd_o.acc_op = bqd_pkg::ACC_HOLD;
    cmd_o.slot = bqd_pkg::SLOT_B0;
    s_ready_o = 1'b0;
    case (state_q)
      bqd_pkg::ST_IDLE: s_ready_o = 1'b1;
      bqd_pkg::ST_DISPATCH: begin
        cmd_o.coef_we = status_i.is_load && status_i.tgt_ok;
      end
      bqd_pkg::ST_RD_B0: begin
        cmd_o.coef_re  = 1'b1;
        cmd_o.slot     = bqd_pkg::SLOT_B0;
        cmd_o.delay_re = 1'b1;
      end
      bqd_pkg::ST_MUL_B0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.coef_re = 1'b1;
        cmd_o.slot    = bqd_pkg::SLOT_B1;
      end
      bqd_pkg::ST_Y: begin
        cmd_o.y_load  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.coef_re = 1'b1;
        cmd_o.slot    = bqd_pkg::SLOT_A1;
      end
      bqd_pkg::ST_FB: begin
        cmd_o.fb_load = 1'b1;
        cmd_o.acc_op  = bqd_pkg::ACC_PROD_W2;
      end
      bqd_pkg::ST_MUL_A1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_fb  = 1'b1;
        cmd_o.coef_re = 1'b1;
        cmd_o.slot    = bqd_pkg::SLOT_B2;
      end
      bqd_pkg::ST_SUB_A1: begin
        cmd_o.acc_op  = bqd_pkg::ACC_SUB_PROD;
        cmd_o.mul_en  = 1'b1;
        cmd_o.coef_re = 1'b1;
        cmd_o.slot    = bqd_pkg::SLOT_A2;
      end
      bqd_pkg::ST_W1: begin
        cmd_o.wr_first = 1'b1;
        cmd_o.acc_op   = bqd_pkg::ACC_PROD;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_fb   = 1'b1;
      end
      bqd_pkg::ST_W2: cmd_o.wr_second = 1'b1;
      bqd_pkg::ST_DONE: begin
        cmd_o.out_load   = !status_i.out_busy;
        cmd_o.out_from_y = !status_i.is_load && status_i.tgt_ok;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/bqd_datapath.sv =====
// Biquad datapath: coefficient and delay memories, shared multiplier, accumulator, result register.
`timescale 1ns / 1ps
`default_nettype none
module bqd_datapath #(
  parameter int SECTIONS = 8,
  parameter int CHANNELS = 2
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_accept_i,
  input  wire                  mode_i,
  input  wire  [2:0]           section_i,
  input  wire                  channel_i,
  input  wire  signed [23:0]   sample_in_i,
  input  wire  [2:0]           coef_slot_i,
  input  wire  signed [25:0]   coef_value_i,
  input  wire                  block_end_i,
  input  wire bqd_pkg::cmd_t   cmd_i,
  output bqd_pkg::status_t     status_o,
  input  wire                  m_ready_i,
  output logic                 m_valid_o,
  output logic signed [23:0]   sample_out_o,
  output logic                 clipped_o,
  output logic                 block_end_out_o
);

  localparam int CoefDepth  = SECTIONS * bqd_pkg::NUM_COEF;
  localparam int CoefAw     = $clog2(CoefDepth);
  localparam int DelayDepth = SECTIONS * CHANNELS;
  localparam int DelayAw    = (DelayDepth > 1) ? $clog2(DelayDepth) : 1;

  // Captured item
  logic                              mode_q;
  logic [2:0]                        sec_q;
  logic                              ch_q;
  logic signed [bqd_pkg::SAMPLE_W-1:0] x_q;
  logic [2:0]                        slot_q;
  logic signed [bqd_pkg::COEF_W-1:0] cv_q;
  logic                              be_q;

  always_ff @(posedge clk_i) begin
    if (s_accept_i) begin
      mode_q <= mode_i;
      sec_q  <= section_i;
      ch_q   <= channel_i;
      x_q    <= sample_in_i;
      slot_q <= coef_slot_i;
      cv_q   <= coef_value_i;
      be_q   <= block_end_i;
    end
  end

  logic sec_ok, ch_ok, slot_ok;
  assign sec_ok  = 32'(sec_q) < SECTIONS;
  assign ch_ok   = 32'(ch_q) < CHANNELS;
  assign slot_ok = 32'(slot_q) < bqd_pkg::NUM_COEF;

  assign status_o.is_load  = (mode_q == bqd_pkg::MODE_LOAD);
  assign status_o.tgt_ok   = (mode_q == bqd_pkg::MODE_LOAD) ? (sec_ok && slot_ok)
                                                            : (sec_ok && ch_ok);
  assign status_o.out_busy = m_valid_o && !m_ready_i;

  // Addresses
  logic [bqd_pkg::ADDR_W-1:0] cbase, caddr_rd, caddr_wr, daddr_full;
  logic [DelayAw-1:0]         daddr;

  assign cbase      = bqd_pkg::ADDR_W'(sec_q) * bqd_pkg::ADDR_W'(bqd_pkg::NUM_COEF);
  assign caddr_rd   = cbase + bqd_pkg::ADDR_W'(cmd_i.slot);
  assign caddr_wr   = cbase + bqd_pkg::ADDR_W'(slot_q);
  assign daddr_full = bqd_pkg::ADDR_W'(sec_q) * bqd_pkg::ADDR_W'(CHANNELS)
                    + bqd_pkg::ADDR_W'(ch_q);
  assign daddr      = daddr_full[DelayAw-1:0];

  // Coefficient memory
  logic signed [bqd_pkg::COEF_W-1:0] coef_mem [CoefDepth];
  logic signed [bqd_pkg::COEF_W-1:0] coef_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_we) begin
      coef_mem[caddr_wr[CoefAw-1:0]] <= cv_q;
    end
    if (cmd_i.coef_re) begin
      coef_q <= coef_mem[caddr_rd[CoefAw-1:0]];
    end
  end

  // Delay memories; entries not yet written read as zero
  logic signed [bqd_pkg::DELAY_W-1:0] dly1_mem [DelayDepth];
  logic signed [bqd_pkg::DELAY_W-1:0] dly2_mem [DelayDepth];
  logic signed [bqd_pkg::DELAY_W-1:0] dly1_q, dly2_q, w1, w2;
  logic [DelayDepth-1:0]              dvalid_q;

  logic signed [bqd_pkg::ACC_W-1:0]   acc_q;
  logic signed [bqd_pkg::PROD_W-1:0]  prod_q;
  logic signed [bqd_pkg::ACC_W-1:0]   acc_sub;
  logic signed [bqd_pkg::DELAY_W-1:0] w1_new, w2_new;

  assign acc_sub = acc_q - bqd_pkg::ACC_W'(prod_q);
  assign w1_new  = bqd_pkg::sat_delay(acc_q);
  assign w2_new  = bqd_pkg::sat_delay(acc_sub);

  always_ff @(posedge clk_i) begin
    if (cmd_i.delay_re) begin
      dly1_q <= dly1_mem[daddr];
      dly2_q <= dly2_mem[daddr];
    end
    if (cmd_i.wr_first) begin
      dly1_mem[daddr] <= w1_new;
    end
    if (cmd_i.wr_second) begin
      dly2_mem[daddr] <= w2_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvalid_q <= '0;
    end else if (cmd_i.wr_second) begin
      dvalid_q[daddr] <= 1'b1;
    end
  end

  assign w1 = dvalid_q[daddr] ? dly1_q : '0;
  assign w2 = dvalid_q[daddr] ? dly2_q : '0;

  // Shared multiplier
  logic signed [bqd_pkg::FB_W-1:0] yfb_q, mul_b;
  assign mul_b = cmd_i.mul_fb ? yfb_q : bqd_pkg::FB_W'(x_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= coef_q * mul_b;
    end
  end

  // y, feedback term and accumulator
  logic signed [bqd_pkg::DELAY_W-1:0] y_q;
  logic signed [28:0]                 y_round;
  assign y_round = bqd_pkg::round_y(y_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.y_load) begin
      y_q <= bqd_pkg::sat_delay(bqd_pkg::ACC_W'(prod_q) + bqd_pkg::ACC_W'(w1));
    end
    if (cmd_i.fb_load) begin
      yfb_q <= bqd_pkg::sat_fb(y_round);
    end
    case (cmd_i.acc_op)
      bqd_pkg::ACC_PROD_W2:  acc_q <= bqd_pkg::ACC_W'(prod_q) + bqd_pkg::ACC_W'(w2);
      bqd_pkg::ACC_SUB_PROD: acc_q <= acc_sub;
      bqd_pkg::ACC_PROD:     acc_q <= bqd_pkg::ACC_W'(prod_q);
      default: ;
    endcase
  end

  // Result register
  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sample_out_o    <= cmd_i.out_from_y ? bqd_pkg::sat_out(y_round) : '0;
      clipped_o       <= cmd_i.out_from_y && bqd_pkg::out_clips(y_round);
      block_end_out_o <= be_q;
    end
  end

  assign m_valid_o = valid_q;

endmodule
`default_nettype wire

// ===== src/biquad_tdf2_multichannel_top.sv =====
// Top level of the multichannel transposed direct form II biquad equalizer section.
//
//  channel   direction  tdata (low bit up)                                   tuser  tlast
//  s_axis    in         section[2:0] channel[3] sample_in[27:4]              mode   block_end
//                       coef_slot[30:28] coef_value[56:31] zero[63:57]
//  m_axis    out        sample_out[23:0]                                     clipped block_end_out
//
// A filter transaction passes through every state from dispatch to done, a coefficient load
// or an out-of-range target goes from dispatch straight to done; the five products of a
// filter item go one after another through a single 26x28 multiplier fed from the
// coefficient memory. Results are loaded in the done state; new items are taken only in idle.
// Reset clears the state machine, the result register and the delay valid bits; no
// clearing pass is needed. A stalled output only holds the block in its final step.
`timescale 1ns / 1ps
`default_nettype none
module biquad_tdf2_multichannel_top #(
  parameter int SECTIONS = 8,
  parameter int CHANNELS = 2
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [63:0] s_axis_tdata_i,   // section, channel, sample_in, coef_slot, coef_value
  input  wire  [0:0]  s_axis_tuser_i,   // mode
  input  wire         s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // sample_out
  output logic [0:0]  m_axis_tuser_o,   // clipped
  output logic        m_axis_tlast_o
);

  bqd_pkg::cmd_t    cmd;
  bqd_pkg::status_t status;
  logic             s_accept;
  logic signed [23:0] sample_out;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;

  bqd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  bqd_datapath #(
    .SECTIONS (SECTIONS),
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_accept_i      (s_accept),
    .mode_i          (s_axis_tuser_i[0]),
    .section_i       (s_axis_tdata_i[2:0]),
    .channel_i       (s_axis_tdata_i[3]),
    .sample_in_i     (s_axis_tdata_i[27:4]),
    .coef_slot_i     (s_axis_tdata_i[30:28]),
    .coef_value_i    (s_axis_tdata_i[56:31]),
    .block_end_i     (s_axis_tlast_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .m_ready_i       (m_axis_tready_i),
    .m_valid_o       (m_axis_tvalid_o),
    .sample_out_o    (sample_out),
    .clipped_o       (m_axis_tuser_o[0]),
    .block_end_out_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = sample_out;

endmodule
`default_nettype wire

// ===== src/bqd_checker.sv =====
// Port-level checks for the biquad equalizer section, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bqd_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid_i,
  input wire        s_axis_tready_o,
  input wire [63:0] s_axis_tdata_i,
  input wire [0:0]  s_axis_tuser_i,
  input wire        s_axis_tlast_i,
  input wire        m_axis_tvalid_o,
  input wire        m_axis_tready_i,
  input wire [23:0] m_axis_tdata_o,
  input wire [0:0]  m_axis_tuser_o,
  input wire        m_axis_tlast_o
);

  logic in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // transactions taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result valid dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("input ready right after a transaction");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != 2'd0)
    else $error("result shown without a pending transaction");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |->
      (m_axis_tdata_o == 24'h7FFFFF) || (m_axis_tdata_o == 24'h800000))
    else $error("clip flag on an unsaturated sample");

endmodule

bind biquad_tdf2_multichannel_top bqd_checker u_bqd_checker (.*);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the multichannel biquad equalizer section.
`timescale 1ns / 1ps
module tb_top;

  localparam int SECTIONS     = 8;
  localparam int CHANNELS     = 2;
  localparam int RANDOM_ITEMS = 600;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 150;
  localparam int MAX_REPORTS  = 10;

  localparam logic [2:0] SLOT_TOP = 3'd7;  // highest code the slot field can carry

  localparam longint COEF_HI = (longint'(1) <<< 25) - 1;
  localparam longint COEF_LO = -(longint'(1) <<< 25);
  localparam longint COEF_ONE = longint'(1) <<< 22;
  localparam longint SMP_HI  = (longint'(1) <<< 23) - 1;
  localparam longint SMP_LO  = -(longint'(1) <<< 23);
  localparam longint ACC_HI  = (longint'(1) <<< 49) - 1;
  localparam longint ACC_LO  = -(longint'(1) <<< 49);
  localparam longint FB_HI   = (longint'(1) <<< 27) - 1;
  localparam longint FB_LO   = -(longint'(1) <<< 27);

  typedef enum int { CF_STABLE, CF_WILD, CF_CORNER } coef_style_e;
  typedef enum int { SM_QUIET, SM_FULL, SM_CORNER } sample_style_e;

  typedef struct {
    logic                                mode;
    logic [2:0]                          section;
    logic                                channel;
    logic signed [bqd_pkg::SAMPLE_W-1:0] sample;
    logic [2:0]                          slot;
    logic signed [bqd_pkg::COEF_W-1:0]   coef;
    logic                                blk_end;
  } eq_item_t;

  typedef struct {
    logic signed [bqd_pkg::SAMPLE_W-1:0] sample;
    logic                                clipped;
    logic                                blk_end;
  } eq_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  eq_item_t   sample_feed[$];
  eq_result_t predicted_out[$];

  // predictor state
  logic signed [bqd_pkg::COEF_W-1:0] coef_mem [SECTIONS*bqd_pkg::NUM_COEF] = '{default: '0};
  longint                   w1_mem [SECTIONS*CHANNELS] = '{default: 0};
  longint                   w2_mem [SECTIONS*CHANNELS] = '{default: 0};

  // stimulus bookkeeping: a section is filtered only once all its words are loaded
  logic [bqd_pkg::NUM_COEF-1:0] coef_written [SECTIONS] = '{default: '0};

  eq_item_t cur_item;
  int       feed_gap = 0;
  bit       feed_burst = 1'b0;
  int       drain_wait = 0;
  bit       drain_burst = 1'b0;
  int       results_seen = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       fail_count = 0;
  int       report_count = 0;
  int       cycle_count = 0;

  biquad_tdf2_multichannel_top #(
    .SECTIONS(SECTIONS),
    .CHANNELS(CHANNELS)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  always #6 clk = ~clk;

  function automatic longint sat_acc(input longint v);
    return (v > ACC_HI) ? ACC_HI : ((v < ACC_LO) ? ACC_LO : v);
  endfunction

  // Q5.45 -> Q.23, round half up
  function automatic longint round_q23(input longint v);
    return (v + (longint'(1) <<< 21)) >>> 22;
  endfunction

  function automatic void biquad_eval(input eq_item_t it, output eq_result_t r);
    int     base;
    int     d;
    longint x;
    longint y;
    longint fb;
    longint w1n;
    longint w2n;
    longint yo;
    r.sample  = '0;
    r.clipped = 1'b0;
    r.blk_end = it.blk_end;
    base = it.section * bqd_pkg::NUM_COEF;
    if (it.mode == bqd_pkg::MODE_LOAD) begin
      if (it.slot < bqd_pkg::NUM_COEF) coef_mem[base + it.slot] = it.coef;
    end else if (it.section < SECTIONS && it.channel < CHANNELS) begin
      d = it.section * CHANNELS + it.channel;
      x = longint'(it.sample);
      y = sat_acc(longint'(coef_mem[base + bqd_pkg::SLOT_B0]) * x + w1_mem[d]);
      fb = round_q23(y);
      fb = (fb > FB_HI) ? FB_HI : ((fb < FB_LO) ? FB_LO : fb);
      w1n = sat_acc(longint'(coef_mem[base + bqd_pkg::SLOT_B1]) * x
                    - longint'(coef_mem[base + bqd_pkg::SLOT_A1]) * fb + w2_mem[d]);
      w2n = sat_acc(longint'(coef_mem[base + bqd_pkg::SLOT_B2]) * x
                    - longint'(coef_mem[base + bqd_pkg::SLOT_A2]) * fb);
      w1_mem[d] = w1n;
      w2_mem[d] = w2n;
      yo = round_q23(y);
      if (yo > SMP_HI || yo < SMP_LO) begin
        yo = (yo > SMP_HI) ? SMP_HI : SMP_LO;
        r.clipped = 1'b1;
      end
      r.sample = yo[bqd_pkg::SAMPLE_W-1:0];
    end
  endfunction

  function automatic int srange(input int a);
    return int'($urandom_range(0, 2 * a)) - a;
  endfunction

  function automatic logic signed [bqd_pkg::COEF_W-1:0] rand_coef(input coef_style_e style,
                                                                    input logic [2:0] slot);
    longint v;
    case (style)
      CF_STABLE: begin
        // |a1| <= 0.5 and |a2| <= 0.25 keep the poles inside the unit circle
        v = (slot == bqd_pkg::SLOT_A2) ? longint'(srange(1 << 20)) : longint'(srange(1 << 21));
      end
      CF_WILD: begin
        v = longint'($urandom);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = COEF_HI;
          1: v = COEF_LO;
          2: v = COEF_ONE;
          3: v = -COEF_ONE;
          default: v = 0;
        endcase
      end
    endcase
    return v[bqd_pkg::COEF_W-1:0];
  endfunction

  function automatic logic signed [bqd_pkg::SAMPLE_W-1:0] rand_sample(input sample_style_e style);
    longint v;
    case (style)
      SM_QUIET: v = ($urandom_range(0, 1) != 0) ? longint'(srange(1 << 12))
                                                : longint'(srange(1 << 20));
      SM_FULL:  v = longint'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: v = SMP_HI;
          1: v = SMP_LO;
          2: v = 1;
          3: v = -1;
          default: v = 0;
        endcase
      end
    endcase
    return v[bqd_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic void queue_load(input logic [2:0] sec, input logic [2:0] slot,
                                     input logic signed [bqd_pkg::COEF_W-1:0] value,
                                     input logic last);
    eq_item_t it;
    it.mode    = bqd_pkg::MODE_LOAD;
    it.section = sec;
    it.channel = 1'($urandom_range(0, 1));
    it.sample  = bqd_pkg::SAMPLE_W'($urandom);
    it.slot    = slot;
    it.coef    = value;
    it.blk_end = last;
    if (slot < bqd_pkg::NUM_COEF) coef_written[sec][slot] = 1'b1;
    sample_feed.push_back(it);
  endfunction

  function automatic void queue_filter(input logic [2:0] sec, input logic ch,
                                       input logic signed [bqd_pkg::SAMPLE_W-1:0] x,
                                       input logic last);
    eq_item_t it;
    it.mode    = bqd_pkg::MODE_FILTER;
    it.section = sec;
    it.channel = ch;
    it.sample  = x;
    it.slot    = 3'($urandom_range(0, SLOT_TOP));
    it.coef    = bqd_pkg::COEF_W'($urandom);
    it.blk_end = last;
    sample_feed.push_back(it);
  endfunction

  // sender
  always @(posedge clk or negedge rst_n) begin
    eq_result_t res;
    bit         free;
    if (!rst_n) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      s_tlast  <= 1'b0;
    end else begin
      free = !s_tvalid || s_tready;
      if (s_tvalid && s_tready) begin
        biquad_eval(cur_item, res);
        predicted_out.push_back(res);
        if ($urandom_range(0, 39) == 0) feed_burst = !feed_burst;
        feed_gap = feed_burst ? 0 : $urandom_range(0, 8);
      end
      if (free) begin
        if (feed_gap > 0 || sample_feed.size() == 0) begin
          if (feed_gap > 0) feed_gap--;
          s_tvalid <= 1'b0;
        end else begin
          cur_item = sample_feed.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{(64 - 57){1'b0}}, cur_item.coef, cur_item.slot, cur_item.sample,
                       cur_item.channel, cur_item.section};
          s_tuser  <= cur_item.mode;
          s_tlast  <= cur_item.blk_end;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk or negedge rst_n) begin
    eq_result_t want;
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (predicted_out.size() == 0) begin
          fail_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("unexpected result: sample %0d clipped %0b last %0b",
                     $signed(m_tdata), m_tuser, m_tlast);
          end
        end else begin
          want = predicted_out.pop_front();
          if (m_tdata !== want.sample || m_tuser[0] !== want.clipped ||
              m_tlast !== want.blk_end) begin
            fail_count++;
            if (report_count < MAX_REPORTS) begin
              report_count++;
              $display("mismatch: expected sample %0d clipped %0b last %0b, got %0d %0b %0b",
                       want.sample, want.clipped, want.blk_end,
                       $signed(m_tdata), m_tuser, m_tlast);
            end
          end
        end
        if ($urandom_range(0, 39) == 0) drain_burst = !drain_burst;
        drain_wait = drain_burst ? 0 : $urandom_range(0, 8);
      end
      if (drain_wait > 0) begin
        drain_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (hold_left == 0);
      end
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("biquad_tdf2_multichannel_top regression: fail");
      $finish;
    end
  end

  initial begin
    int            n_rand;
    int            pick;
    int            run_len;
    int            k;
    int            first;
    logic [2:0]    sec;
    logic [2:0]    slot;
    logic          ch;
    coef_style_e   cstyle;
    sample_style_e sstyle;
    logic [2:0]    ready_q[$];

    // section 0: extreme coefficients, drives clipping and accumulator saturation
    queue_load(3'd0, bqd_pkg::SLOT_B0, COEF_HI[bqd_pkg::COEF_W-1:0], 1'b0);
    queue_load(3'd0, bqd_pkg::SLOT_B1, COEF_LO[bqd_pkg::COEF_W-1:0], 1'b0);
    queue_load(3'd0, bqd_pkg::SLOT_B2, COEF_ONE[bqd_pkg::COEF_W-1:0], 1'b0);
    queue_load(3'd0, bqd_pkg::SLOT_A1, COEF_LO[bqd_pkg::COEF_W-1:0], 1'b0);
    queue_load(3'd0, bqd_pkg::SLOT_A2, COEF_HI[bqd_pkg::COEF_W-1:0], 1'b1);
    // section 1: pass-through
    queue_load(3'd1, bqd_pkg::SLOT_B0, COEF_ONE[bqd_pkg::COEF_W-1:0], 1'b0);
    queue_load(3'd1, bqd_pkg::SLOT_B1, '0, 1'b0);
    queue_load(3'd1, bqd_pkg::SLOT_B2, '0, 1'b0);
    queue_load(3'd1, bqd_pkg::SLOT_A1, '0, 1'b0);
    queue_load(3'd1, bqd_pkg::SLOT_A2, '0, 1'b0);
    // loads to slots past a2 must be dropped, not alias into the next section
    queue_load(3'd0, bqd_pkg::SLOT_A2 + 3'd1, '0, 1'b1);
    queue_load(3'd0, bqd_pkg::SLOT_A2 + 3'd2, '0, 1'b0);
    queue_load(3'd7, SLOT_TOP, COEF_LO[bqd_pkg::COEF_W-1:0], 1'b0);
    queue_filter(3'd1, 1'b0, SMP_HI[bqd_pkg::SAMPLE_W-1:0], 1'b0);
    queue_filter(3'd1, 1'b0, SMP_LO[bqd_pkg::SAMPLE_W-1:0], 1'b0);
    queue_filter(3'd1, 1'b0, '0, 1'b1);
    queue_filter(3'd0, 1'b0, SMP_HI[bqd_pkg::SAMPLE_W-1:0], 1'b0);
    queue_filter(3'd0, 1'b0, SMP_LO[bqd_pkg::SAMPLE_W-1:0], 1'b0);
    queue_filter(3'd0, 1'b1, -24'sd1, 1'b0);
    queue_filter(3'd0, 1'b1, 24'sd1, 1'b0);
    queue_filter(3'd0, 1'b0, '0, 1'b1);
    queue_filter(3'd1, 1'b1, SMP_LO[bqd_pkg::SAMPLE_W-1:0], 1'b1);

    // out-of-range filter targets cannot be encoded with these widths
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      ready_q.delete();
      for (k = 0; k < SECTIONS; k++) begin
        if (&coef_written[k]) ready_q.push_back(k[2:0]);
      end
      pick = $urandom_range(0, 99);
      if (pick < 12 || ready_q.size() == 0) begin
        sec    = 3'($urandom_range(0, SECTIONS - 1));
        cstyle = coef_style_e'($urandom_range(0, 2));
        first  = $urandom_range(0, bqd_pkg::NUM_COEF - 1);
        for (k = 0; k < bqd_pkg::NUM_COEF; k++) begin
          slot = 3'((first + k) % bqd_pkg::NUM_COEF);
          queue_load(sec, slot, rand_coef(cstyle, slot), ($urandom_range(0, 7) == 0));
        end
        n_rand += bqd_pkg::NUM_COEF;
      end else if (pick < 18) begin
        sec = 3'($urandom_range(0, SECTIONS - 1));
        if ($urandom_range(0, 1) != 0) begin
          queue_load(sec, 3'($urandom_range(bqd_pkg::SLOT_A2 + 1, SLOT_TOP)),
                     bqd_pkg::COEF_W'($urandom), 1'($urandom_range(0, 1)));
        end else begin
          slot = 3'($urandom_range(0, bqd_pkg::NUM_COEF - 1));
          queue_load(sec, slot, rand_coef(CF_WILD, slot), 1'($urandom_range(0, 1)));
          n_rand++;
        end
      end else begin
        sec     = ready_q[$urandom_range(0, ready_q.size() - 1)];
        ch      = 1'($urandom_range(0, CHANNELS - 1));
        run_len = $urandom_range(1, 12);
        sstyle  = sample_style_e'($urandom_range(0, 2));
        for (k = 0; k < run_len; k++) begin
          queue_filter(sec, ch, rand_sample(sstyle),
                       (k == run_len - 1) || ($urandom_range(0, 15) == 0));
        end
        n_rand += run_len;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (sample_feed.size() != 0 || s_tvalid || predicted_out.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    fail_count += predicted_out.size();
    if (fail_count == 0) begin
      $display("biquad_tdf2_multichannel_top regression: pass");
    end else begin
      $display("biquad_tdf2_multichannel_top regression: fail");
    end
    $finish;
  end

endmodule
